FILE: hw/rtl/nckl_pkg.sv
`default_nettype none
package nckl_pkg;

   // table sizes
   localparam int CODEPOINT_LIMIT = 1114113;
   localparam int BUCKET_COUNT    = 4096;
   localparam int ENTRY_COUNT     = 8192;

   // field widths
   localparam int CP_W      = 21;
   localparam int CODE_W    = 12;
   localparam int KEY_W     = 64;
   localparam int KEY_HI_W  = 42;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 7;
   localparam int BB_W      = 4;
   localparam int START_W   = 14;
   localparam int SHIFT_W   = 7;
   localparam int HASH_MW   = 16;
   localparam int CHAR_AW   = $clog2(CODEPOINT_LIMIT);
   localparam int BKT_AW    = $clog2(BUCKET_COUNT + 1);
   localparam int ENT_AW    = $clog2(ENTRY_COUNT);
   localparam int ENT_DW    = KEY_W + VALUE_W + COUNT_W;
   localparam int QUEUE_DEPTH = 2;

   // mode codes
   localparam logic [1:0] MODE_LD_CODE   = 2'd0;
   localparam logic [1:0] MODE_LD_BUCKET = 2'd1;
   localparam logic [1:0] MODE_LD_ENTRY  = 2'd2;
   localparam logic [1:0] MODE_QUERY     = 2'd3;

   // splitmix64 finaliser constants
   localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LD_CODE,
      OP_LD_BUCKET,
      OP_LD_ENTRY,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CP_W-1:0]       index;
      logic [KEY_W-1:0]      key_lo;
      logic [KEY_HI_W-1:0]   key_hi;
      logic [VALUE_W-1:0]    value;
      logic [COUNT_W-1:0]    count;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PACK_RD,
      BK_PACK_WT,
      BK_HASH_WT,
      BK_DIR_A,
      BK_DIR_B,
      BK_DIR_C,
      BK_SCAN_RD,
      BK_SCAN_WT,
      BK_DONE
   } back_state_type;

   typedef enum logic [2:0] {
      MIX_IDLE,
      MIX_M0,
      MIX_M1,
      MIX_M2,
      MIX_DONE
   } mix_state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/nckl_if.sv
`default_nettype none
interface nckl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [20:0] index;
   logic [63:0] key_lo;
   logic [41:0] key_hi;
   logic [31:0] load_value;
   logic [6:0]  load_count;
   modport source (output valid, mode, index, key_lo, key_hi, load_value, load_count,
                   input ready);
   modport sink (input valid, mode, index, key_lo, key_hi, load_value, load_count,
                 output ready);
endinterface

interface nckl_rsp_if;
   logic        valid;
   logic        ready;
   logic        encodable;
   logic        found;
   logic [12:0] entry_position;
   logic [31:0] posting_offset;
   logic [6:0]  posting_count;
   modport source (output valid, encodable, found, entry_position, posting_offset,
                   posting_count, input ready);
   modport sink (input valid, encodable, found, entry_position, posting_offset,
                 posting_count, output ready);
endinterface

interface nckl_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/nckl_ram.sv
`default_nettype none
module nckl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/nckl_front.sv
`default_nettype none
module nckl_front
   import nckl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   nckl_req_if.sink     req_chan,
   input  wire logic    clearing,
   input  wire logic    pop,
   output queue_head_type head
);
   queue_item_type slot_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           push;
   queue_item_type item;

   // classify the incoming item, out-of-range loads become no-ops
   always_comb begin
      item.index  = req_chan.index;
      item.key_lo = req_chan.key_lo;
      item.key_hi = req_chan.key_hi;
      item.value  = req_chan.load_value;
      item.count  = req_chan.load_count;
      unique case (req_chan.mode)
         MODE_LD_CODE: begin
            item.op = (req_chan.index < CP_W'(CODEPOINT_LIMIT)) ? OP_LD_CODE : OP_NOP;
         end
         MODE_LD_BUCKET: begin
            item.op = (req_chan.index <= CP_W'(BUCKET_COUNT)) ? OP_LD_BUCKET : OP_NOP;
         end
         MODE_LD_ENTRY: begin
            item.op = (req_chan.index < CP_W'(ENTRY_COUNT)) ? OP_LD_ENTRY : OP_NOP;
         end
         MODE_QUERY: begin
            item.op = OP_QUERY;
         end
         default: begin
            item.op = OP_NOP;
         end
      endcase
   end

   // queue control
   assign req_chan.ready = (cnt_ff != 2'(QUEUE_DEPTH)) && !clearing;
   assign push = req_chan.valid && req_chan.ready;
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
endmodule
`default_nettype wire

FILE: hw/rtl/nckl_mix.sv
`default_nettype none
module nckl_mix
   import nckl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] key,
   output logic             done,
   output logic [63:0]      hash
);
   mix_state_type state_ff, state_in;
   logic          round_ff, round_in;
   logic [63:0]   x_ff, x_in;
   logic [63:0]   acc_ff, acc_in;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;
   logic [63:0]   coef;
   logic [63:0]   y;

   // one shared 32x32 multiplier, three partial products per 64-bit multiply
   assign coef  = round_ff ? MIX_C2 : MIX_C1;
   assign mul_a = (state_ff == MIX_M2) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b = (state_ff == MIX_M1) ? coef[63:32] : coef[31:0];
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   assign y     = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
   assign done  = (state_ff == MIX_DONE);
   assign hash  = x_ff;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         MIX_IDLE: begin
            if (start) begin
               x_in     = key ^ (key >> 30);
               round_in = 1'b0;
               state_in = MIX_M0;
            end
         end
         MIX_M0: begin
            acc_in   = mul_p;
            state_in = MIX_M1;
         end
         MIX_M1: begin
            acc_in   = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
            state_in = MIX_M2;
         end
         MIX_M2: begin
            if (!round_ff) begin
               x_in     = y ^ (y >> 27);
               round_in = 1'b1;
               state_in = MIX_M0;
            end else begin
               x_in     = y ^ (y >> 31);
               state_in = MIX_DONE;
            end
         end
         MIX_DONE: begin
            state_in = MIX_IDLE;
         end
         default: begin
            state_in = MIX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MIX_IDLE;
      end else begin
         state_ff <= state_in;
      end
      round_ff <= round_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/nckl_back.sv
`default_nettype none
module nckl_back
   import nckl_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_head_type head,
   output logic                pop,
   output logic                clearing,
   nckl_rsp_if.source          rsp_chan,
   nckl_csr_if.sink            csr_chan
);
   back_state_type       state_ff, state_in;
   logic [CHAR_AW-1:0]   clr_ff, clr_in;
   logic [BB_W-1:0]      bb_ff;
   logic [KEY_W-1:0]     key_lo_ff, key_lo_in;
   logic [KEY_HI_W-1:0]  key_hi_ff, key_hi_in;
   logic [KEY_W-1:0]     acc_ff, acc_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [2:0]           pidx_ff, pidx_in;
   logic [BKT_AW-1:0]    b_ff, b_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic [START_W-1:0]   end_ff, end_in;
   logic [START_W-1:0]   i_ff, i_in;
   logic                 res_enc_ff, res_enc_in;
   logic                 res_found_ff, res_found_in;
   logic [ENT_AW-1:0]    res_pos_ff, res_pos_in;
   logic [VALUE_W-1:0]   res_off_ff, res_off_in;
   logic [COUNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_enc_ff, out_found_ff;
   logic [ENT_AW-1:0]    out_pos_ff;
   logic [VALUE_W-1:0]   out_off_ff;
   logic [COUNT_W-1:0]   out_cnt_ff;
   logic                 out_load;
   logic                 out_free;

   logic                 char_we;
   logic [CHAR_AW-1:0]   char_waddr;
   logic [CODE_W-1:0]    char_wdata;
   logic [CODE_W-1:0]    char_rdata;
   logic                 bkt_we;
   logic [BKT_AW-1:0]    bkt_waddr;
   logic [START_W-1:0]   bkt_wdata;
   logic [BKT_AW-1:0]    bkt_raddr;
   logic [START_W-1:0]   bkt_rdata;
   logic                 ent_we;
   logic [ENT_DW-1:0]    ent_rdata;
   logic [KEY_W-1:0]     ent_key;

   logic                 mix_start;
   logic                 mix_done;
   logic [63:0]          mix_hash;
   logic [HASH_MW-1:0]   masked;

   logic [CP_W-1:0]      cp;
   logic                 wide;
   logic [7:0]           shift_sum;
   logic [KEY_W-1:0]     field;

   // table memories
   nckl_ram #(.WIDTH(CODE_W), .DEPTH(CODEPOINT_LIMIT)) u_char_ram (
      .clock (clock),
      .we    (char_we),
      .waddr (char_waddr),
      .wdata (char_wdata),
      .raddr (cp),
      .rdata (char_rdata)
   );

   nckl_ram #(.WIDTH(START_W), .DEPTH(BUCKET_COUNT + 1)) u_bkt_ram (
      .clock (clock),
      .we    (bkt_we),
      .waddr (bkt_waddr),
      .wdata (bkt_wdata),
      .raddr (bkt_raddr),
      .rdata (bkt_rdata)
   );

   nckl_ram #(.WIDTH(ENT_DW), .DEPTH(ENTRY_COUNT)) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (head.item.index[ENT_AW-1:0]),
      .wdata ({head.item.key_lo, head.item.value, head.item.count}),
      .raddr (i_ff[ENT_AW-1:0]),
      .rdata (ent_rdata)
   );

   nckl_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .key   (acc_ff),
      .done  (mix_done),
      .hash  (mix_hash)
   );

   // configuration register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bb_ff <= '0;
      end else if (csr_chan.valid) begin
         bb_ff <= csr_chan.data;
      end
   end

   // codepoint of the current packing step
   always_comb begin
      unique case (pidx_ff)
         3'd0: cp = key_lo_ff[CP_W-1:0];
         3'd1: cp = key_lo_ff[2*CP_W-1:CP_W];
         3'd2: cp = key_lo_ff[3*CP_W-1:2*CP_W];
         3'd3: cp = key_hi_ff[CP_W-1:0];
         3'd4: cp = key_hi_ff[2*CP_W-1:CP_W];
         default: cp = '0;
      endcase
   end

   assign wide      = (char_rdata == '0);
   assign shift_sum = {1'b0, shift_ff} + (wide ? 8'(CODE_W + CP_W) : 8'(CODE_W));
   assign field     = wide ? {{(KEY_W-CODE_W-CP_W){1'b0}}, cp, {CODE_W{1'b0}}}
                           : {{(KEY_W-CODE_W){1'b0}}, char_rdata};
   assign masked    = mix_hash[HASH_MW-1:0] & ~({HASH_MW{1'b1}} << bb_ff);
   assign ent_key   = ent_rdata[ENT_DW-1:VALUE_W+COUNT_W];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign clearing  = (state_ff == BK_CLEAR);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      key_lo_in    = key_lo_ff;
      key_hi_in    = key_hi_ff;
      acc_in       = acc_ff;
      shift_in     = shift_ff;
      pidx_in      = pidx_ff;
      b_in         = b_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      i_in         = i_ff;
      res_enc_in   = res_enc_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      res_off_in   = res_off_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_load     = 1'b0;
      pop          = 1'b0;
      mix_start    = 1'b0;
      char_we      = 1'b0;
      char_waddr   = head.item.index;
      char_wdata   = head.item.value[CODE_W-1:0];
      bkt_we       = 1'b0;
      bkt_waddr    = head.item.index[BKT_AW-1:0];
      bkt_wdata    = head.item.value[START_W-1:0];
      bkt_raddr    = b_ff;
      ent_we       = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            char_we    = 1'b1;
            char_waddr = clr_ff;
            char_wdata = '0;
            bkt_we     = (clr_ff <= CHAR_AW'(BUCKET_COUNT));
            bkt_waddr  = clr_ff[BKT_AW-1:0];
            bkt_wdata  = '0;
            if (clr_ff == CHAR_AW'(CODEPOINT_LIMIT - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (head.valid) begin
               pop          = 1'b1;
               key_lo_in    = head.item.key_lo;
               key_hi_in    = head.item.key_hi;
               acc_in       = '0;
               shift_in     = '0;
               pidx_in      = '0;
               res_enc_in   = 1'b0;
               res_found_in = 1'b0;
               res_pos_in   = '0;
               res_off_in   = '0;
               res_cnt_in   = '0;
               state_in     = BK_DONE;
               unique case (head.item.op)
                  OP_LD_CODE:   char_we  = 1'b1;
                  OP_LD_BUCKET: bkt_we   = 1'b1;
                  OP_LD_ENTRY:  ent_we   = 1'b1;
                  OP_QUERY:     state_in = BK_PACK_RD;
                  default: ;
               endcase
            end
         end
         BK_PACK_RD: begin
            if (cp == '0) begin
               if (acc_ff != '0) begin
                  res_enc_in = 1'b1;
                  mix_start  = 1'b1;
                  state_in   = BK_HASH_WT;
               end else begin
                  state_in = BK_DONE;
               end
            end else if (cp >= CP_W'(CODEPOINT_LIMIT)) begin
               state_in = BK_DONE;
            end else begin
               state_in = BK_PACK_WT;
            end
         end
         BK_PACK_WT: begin
            if (shift_sum > 8'(KEY_W)) begin
               state_in = BK_DONE;
            end else begin
               acc_in   = acc_ff | (field << shift_ff[5:0]);
               shift_in = shift_sum[SHIFT_W-1:0];
               pidx_in  = pidx_ff + 1'b1;
               state_in = BK_PACK_RD;
            end
         end
         BK_HASH_WT: begin
            if (mix_done) begin
               if (masked >= HASH_MW'(BUCKET_COUNT)) begin
                  state_in = BK_DONE;
               end else begin
                  b_in     = masked[BKT_AW-1:0];
                  state_in = BK_DIR_A;
               end
            end
         end
         BK_DIR_A: begin
            state_in = BK_DIR_B;
         end
         BK_DIR_B: begin
            bkt_raddr = b_ff + 1'b1;
            start_in  = bkt_rdata;
            state_in  = BK_DIR_C;
         end
         BK_DIR_C: begin
            end_in   = bkt_rdata;
            i_in     = start_ff;
            state_in = BK_SCAN_RD;
         end
         BK_SCAN_RD: begin
            if (i_ff < end_ff && i_ff < START_W'(ENTRY_COUNT)) begin
               state_in = BK_SCAN_WT;
            end else begin
               state_in = BK_DONE;
            end
         end
         BK_SCAN_WT: begin
            if (ent_key == acc_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = i_ff[ENT_AW-1:0];
               res_off_in   = ent_rdata[VALUE_W+COUNT_W-1:COUNT_W];
               res_cnt_in   = ent_rdata[COUNT_W-1:0];
               state_in     = BK_DONE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = BK_SCAN_RD;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_load     = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      key_lo_ff    <= key_lo_in;
      key_hi_ff    <= key_hi_in;
      acc_ff       <= acc_in;
      shift_ff     <= shift_in;
      pidx_ff      <= pidx_in;
      b_ff         <= b_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      i_ff         <= i_in;
      res_enc_ff   <= res_enc_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      res_off_ff   <= res_off_in;
      res_cnt_ff   <= res_cnt_in;
      if (out_load) begin
         out_enc_ff   <= res_enc_ff;
         out_found_ff <= res_found_ff;
         out_pos_ff   <= res_pos_ff;
         out_off_ff   <= res_off_ff;
         out_cnt_ff   <= res_cnt_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.encodable      = out_enc_ff;
   assign rsp_chan.found          = out_found_ff;
   assign rsp_chan.entry_position = out_pos_ff;
   assign rsp_chan.posting_offset = out_off_ff;
   assign rsp_chan.posting_count  = out_cnt_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !rsp_chan.valid) else $error("result during clear");
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == BK_IDLE) && head.valid) else $error("pop outside idle");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SCAN_WT) |-> (i_ff < START_W'(ENTRY_COUNT) && i_ff < end_ff))
      else $error("scan out of range");
endmodule
`default_nettype wire

FILE: hw/rtl/ngram_compact_key_lookup_unit.sv
`default_nettype none
// channel   dir  handshake      content
// req_chan  in   valid/ready    mode, index, key_lo, key_hi, load_value, load_count
// rsp_chan  out  valid/ready    encodable, found, entry_position, posting_offset,
//                               posting_count
// csr_chan  in   valid/ready    bucket_bits (4 bits)
//
// a query packs its codepoints one by one, closes the key, hashes it in the hash unit
// (one shared 32x32 multiplier), reads the bucket directory and scans the bucket's
// entries until a key matches; every item, load or query, is taken from the queue and gives one result
// after reset a clearing pass zeroes the code table and bucket
// directory; no item is taken meanwhile, configuration writes are accepted
// a two-item queue and the result register let input and result stall on their own
module ngram_compact_key_lookup_unit
   import nckl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   nckl_req_if.sink   req_chan,
   nckl_rsp_if.source rsp_chan,
   nckl_csr_if.sink   csr_chan
);
   queue_head_type head;
   logic           pop;
   logic           clearing;

   // input queue and classification
   nckl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .clearing (clearing),
      .pop      (pop),
      .head     (head)
   );

   // table access, hashing and scan
   nckl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );
endmodule
`default_nettype wire

FILE: bench/nckl_lookup_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module nckl_lookup_checker
   import nckl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   nckl_req_if.sink  req_mon,
   nckl_rsp_if.sink  rsp_mon,
   nckl_csr_if.sink  csr_mon,
   output int        fail_count,
   output int        pending_count
);

   typedef struct {
      logic        encodable;
      logic        found;
      logic [12:0] entry_position;
      logic [31:0] posting_offset;
      logic [6:0]  posting_count;
   } lookup_result_type;

   // shadow tables
   logic [CODE_W-1:0]  code_shadow [int];
   logic [START_W-1:0] start_shadow [0:BUCKET_COUNT];
   logic [KEY_W-1:0]   key_shadow [int];
   logic [VALUE_W-1:0] offset_shadow [int];
   logic [COUNT_W-1:0] count_shadow [int];
   logic [BB_W-1:0]    bucket_bits_shadow;
   lookup_result_type  expected_results [$];

   function automatic logic [63:0] splitmix_finalise(logic [63:0] x);
      x = x ^ (x >> 30);
      x = x * MIX_C1;
      x = x ^ (x >> 27);
      x = x * MIX_C2;
      return x ^ (x >> 31);
   endfunction

   // pack the query codepoints, returns zero when not encodable
   function automatic logic [63:0] compact_key(logic [63:0] lo, logic [41:0] hi);
      logic [20:0]  cp;
      logic [11:0]  code;
      logic [63:0]  acc;
      int           shift;
      int           width;
      acc   = '0;
      shift = 0;
      for (int i = 0; i < 5; i++) begin
         cp = (i < 3) ? lo[21*i +: 21] : hi[21*(i-3) +: 21];
         if (cp == 0) break;
         if (cp >= CODEPOINT_LIMIT) return '0;
         code  = code_shadow.exists(int'(cp)) ? code_shadow[int'(cp)] : '0;
         width = (code != 0) ? CODE_W : CODE_W + CP_W;
         if (shift + width > 64) return '0;
         acc   = acc | (((code != 0) ? 64'(code) : (64'(cp) << CODE_W)) << shift);
         shift = shift + width;
      end
      return acc;
   endfunction

   function automatic lookup_result_type lookup(logic [1:0] mode, logic [20:0] idx,
         logic [63:0] lo, logic [41:0] hi, logic [31:0] val, logic [6:0] cnt);
      lookup_result_type r;
      logic [63:0]    packed_key;
      logic [63:0]    bkt;
      int             first;
      int             last;
      r = '{default: '0};
      case (mode)
         MODE_LD_CODE: if (idx < CODEPOINT_LIMIT) code_shadow[int'(idx)] = val[11:0];
         MODE_LD_BUCKET: if (idx <= BUCKET_COUNT) start_shadow[idx] = val[13:0];
         MODE_LD_ENTRY: begin
            if (idx < ENTRY_COUNT) begin
               key_shadow[int'(idx)]    = lo;
               offset_shadow[int'(idx)] = val;
               count_shadow[int'(idx)]  = cnt;
            end
         end
         default: begin
            packed_key = compact_key(lo, hi);
            if (packed_key != 0) begin
               r.encodable = 1'b1;
               bkt = splitmix_finalise(packed_key) & ((64'd1 << bucket_bits_shadow) - 1);
               if (bkt < BUCKET_COUNT) begin
                  first = start_shadow[bkt];
                  last  = start_shadow[bkt+1];
                  for (int i = first; i < last && i < ENTRY_COUNT; i++) begin
                     if (key_shadow.exists(i) && key_shadow[i] == packed_key) begin
                        r.found          = 1'b1;
                        r.entry_position = 13'(i);
                        r.posting_offset = offset_shadow[i];
                        r.posting_count  = count_shadow[i];
                        break;
                     end
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   // watch all three channels
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (reset) begin
         for (int i = 0; i <= BUCKET_COUNT; i++) start_shadow[i] = '0;
         code_shadow.delete();
         bucket_bits_shadow = '0;
         fail_count         = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) bucket_bits_shadow = csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            expected_results = {expected_results, lookup(req_mon.mode, req_mon.index,
               req_mon.key_lo, req_mon.key_hi, req_mon.load_value, req_mon.load_count)};
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result item with nothing expected", $time);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r.encodable !== rsp_mon.encodable || exp_r.found !== rsp_mon.found
                   || exp_r.entry_position !== rsp_mon.entry_position
                   || exp_r.posting_offset !== rsp_mon.posting_offset
                   || exp_r.posting_count !== rsp_mon.posting_count) begin
                  $display("%0t: mismatch expected enc=%b fnd=%b pos=%0d off=%h cnt=%0d",
                     $time, exp_r.encodable, exp_r.found, exp_r.entry_position,
                     exp_r.posting_offset, exp_r.posting_count);
                  $display("%0t:          actual   enc=%b fnd=%b pos=%0d off=%h cnt=%0d",
                     $time, rsp_mon.encodable, rsp_mon.found, rsp_mon.entry_position,
                     rsp_mon.posting_offset, rsp_mon.posting_count);
                  fail_count++;
               end
            end
         end
      end
      pending_count <= expected_results.size();
   end

endmodule
`default_nettype wire

FILE: bench/tb_ngram_compact_key_lookup_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_ngram_compact_key_lookup_unit;
   import nckl_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   bit   long_hold = 1'b0;

   nckl_req_if req_chan ();
   nckl_rsp_if rsp_chan ();
   nckl_csr_if csr_chan ();

   ngram_compact_key_lookup_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   nckl_lookup_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .csr_mon       (csr_chan.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // small pool of codepoints given codes
   logic [20:0] coded_cps [$];

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_QUERY;
      req_chan.index      = '0;
      req_chan.key_lo     = '0;
      req_chan.key_hi     = '0;
      req_chan.load_value = '0;
      req_chan.load_count = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.data       = '0;
   end

   // result side: random back-pressure before each item, with one long hold-off
   initial begin : receiver
      int gap;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_item(logic [1:0] mode, logic [20:0] idx, logic [63:0] lo,
                            logic [41:0] hi, logic [31:0] val, logic [6:0] cnt,
                            bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.index      <= idx;
      req_chan.key_lo     <= lo;
      req_chan.key_hi     <= hi;
      req_chan.load_value <= val;
      req_chan.load_count <= cnt;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_and_write_csr(logic [3:0] bits);
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= bits;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [20:0] pick_cp();
      case ($urandom_range(0, 5))
         0: return 21'($urandom_range(1, 255));
         1: return coded_cps[$urandom_range(0, coded_cps.size()-1)];
         2: return 21'($urandom_range(1, CODEPOINT_LIMIT - 1));
         3: return 21'(CODEPOINT_LIMIT - 1);
         default: return coded_cps[$urandom_range(0, coded_cps.size()-1)];
      endcase
   endfunction

   // fill buckets and entries, three entries per bucket
   task automatic build_table(int nbuckets, bit fast);
      for (int b = 0; b <= nbuckets; b++)
         send_item(MODE_LD_BUCKET, 21'(b), '0, '0, 32'(b * 3), '0, fast);
      // entries start with random keys; real keys are stored before some queries
      for (int e = 0; e < nbuckets * 3; e++)
         send_item(MODE_LD_ENTRY, 21'(e), {$urandom(), $urandom()}, '0, $urandom(),
                   7'($urandom()), fast);
   endtask

   task automatic random_query(output logic [63:0] lo, output logic [41:0] hi);
      int n;
      n  = $urandom_range(1, 5);
      lo = {1'($urandom()), 63'(0)};
      hi = '0;
      for (int i = 0; i < n; i++) begin
         if (i < 3) lo[21*i +: 21] = pick_cp();
         else hi[21*(i-3) +: 21] = pick_cp();
      end
      if ($urandom_range(0, 9) == 0) begin
         lo = {$urandom(), $urandom()};
         hi = {10'($urandom()), $urandom()};
      end
   endtask

   initial begin : stimulus
      logic [63:0] lo;
      logic [41:0] hi;
      logic [63:0] pk;
      logic [63:0] hb;
      int          nb;
      int          sel;
      logic [3:0]  bb_list [4] = '{4'd0, 4'd3, 4'd12, 4'd15};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // code table: a few coded codepoints, including extremes
      coded_cps = '{21'd1, 21'd97, 21'd98, 21'd255, 21'h10ffff, 21'd1114112};
      foreach (coded_cps[i])
         send_item(MODE_LD_CODE, coded_cps[i], '0, '0, 32'hfffff000 | 32'(i + 1), '0, 0);
      coded_cps = coded_cps[0:4];
      for (int i = 0; i < 20; i++) begin
         coded_cps = {coded_cps, 21'($urandom_range(256, 4000))};
         send_item(MODE_LD_CODE, coded_cps[$], '0, '0, $urandom_range(0, 4095), '0, 0);
      end
      // out-of-range loads are ignored
      send_item(MODE_LD_CODE, 21'h1fffff, '0, '0, 32'hfff, '0, 0);
      send_item(MODE_LD_BUCKET, 21'h1fffff, '0, '0, 32'hffffffff, '0, 0);
      send_item(MODE_LD_ENTRY, 21'h1fffff, '1, '0, '1, '1, 0);

      for (int phase = 0; phase < 4; phase++) begin
         drain_and_write_csr(bb_list[phase]);
         nb = (phase == 2) ? 64 : 16;
         build_table(nb, phase == 1);
         // directed queries: empty key, too long, out of range, edge codepoints
         send_item(MODE_QUERY, '0, '0, '0, '0, '0, 0);
         send_item(MODE_QUERY, '0, {1'b1, 63'(0)}, '0, '0, '0, 0);
         send_item(MODE_QUERY, '0, {1'b0, 21'd300, 21'd301, 21'd302}, {21'd5, 21'd6},
                   '0, '0, 0);
         send_item(MODE_QUERY, '0, {1'b0, 42'd0, 21'h1fffff}, '0, '0, '0, 0);
         send_item(MODE_QUERY, '0, {1'b0, 21'd1, 21'd1, 21'd1}, {21'd1, 21'd1}, '0, '0, 0);
         send_item(MODE_QUERY, '0, {22'd0, 21'd1114112, 21'd97}, '0, '0, '0, 0);
         // random queries, some preceded by storing their packed key in their bucket
         for (int i = 0; i < 80; i++) begin
            random_query(lo, hi);
            if (phase == 0 && i == 30) long_hold = 1'b1;
            sel = $urandom_range(0, 7);
            if (sel == 0)
               send_item(MODE_LD_CODE, pick_cp(), '0, '0, $urandom_range(0, 4095), '0, 0);
            else begin
               if (sel <= 2) begin
                  pk = checker_i.compact_key(lo, hi);
                  hb = checker_i.splitmix_finalise(pk) & ((64'd1 << bb_list[phase]) - 64'd1);
                  if (pk != '0 && hb < 64'(nb))
                     send_item(MODE_LD_ENTRY, 21'(hb * 3 + 64'($urandom_range(0, 2))), pk,
                               '0, $urandom(), 7'($urandom()), 0);
               end
               send_item(MODE_QUERY, '0, lo, hi, $urandom(), '0, phase == 3);
            end
         end
      end

      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // the clearing pass alone takes over 4.4 ms
   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
